[design/strong_probable_prime_test_defines.svh]
// Assertion macros shared by the strong probable prime test.
`ifndef STRONG_PROBABLE_PRIME_TEST_DEFINES_SVH
`define STRONG_PROBABLE_PRIME_TEST_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SPP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SPP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/spp_pkg.sv]
package spp_pkg;

   // Default datapath width and fixed port widths.
   localparam int SPP_WIDTH_DEFAULT = 32;
   localparam int SPP_CAND_W        = 32;
   localparam int SPP_BASE_W        = 32;
   localparam logic [SPP_BASE_W-1:0] SPP_BASE_RESET = 32'd2;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SPLIT,
      ST_EXP,
      ST_MUL_Y,
      ST_SHIFT,
      ST_MUL_W,
      ST_FINAL,
      ST_SQR_TEST,
      ST_SQR_WAIT,
      ST_SQR_CHECK,
      ST_POST_ERR,
      ST_POST_PRIME,
      ST_POST_COMP
   } spp_state_type;

   // Operand selection for the modular multiplier.
   typedef enum logic [1:0] {
      MUL_YW,
      MUL_WW,
      MUL_YY
   } spp_mul_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load;
      logic           split_shift;
      logic           r_shift;
      logic           mul_start;
      spp_mul_op_type mul_op;
      logic           y_from_prod;
      logic           w_from_prod;
      logic           j_inc;
      logic           post;
      logic           post_prime;
      logic           post_error;
   } spp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic input_bad;
      logic r_lsb;
      logic r_more;
      logic y_is_one;
      logic y_is_m;
      logic y_le_one;
      logic j_lt_s;
      logic mul_done;
      logic mul_busy;
      logic out_free;
   } spp_status_type;

endpackage

[design/spp_mulmod.sv]
module spp_mulmod import spp_pkg::*; #(
   parameter int WIDTH = SPP_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] mul_x,
   input  logic [WIDTH-1:0] mul_y,
   input  logic [WIDTH-1:0] modulus,
   output logic             busy,
   output logic             done,
   output logic [WIDTH-1:0] product
);

   localparam int CW = $clog2(WIDTH);
   localparam int EW = WIDTH + 2;

   logic             busy_ff;
   logic             done_ff;
   logic [WIDTH-1:0] acc_ff;
   logic [WIDTH-1:0] acc_in;
   logic [WIDTH-1:0] x_ff;
   logic [WIDTH-1:0] mplier_ff;
   logic [CW-1:0]    cnt_ff;
   logic [WIDTH-1:0] addend;
   logic [EW-1:0]    sum;
   logic [EW-1:0]    mod1;
   logic [EW-1:0]    mod2;

   // One multiplier bit per cycle: acc = (2*acc + bit*x) mod n, with 2*acc + x below 3n.
   always_comb begin
      addend = mplier_ff[WIDTH-1] ? x_ff : '0;
      sum    = {1'b0, acc_ff, 1'b0} + {2'b00, addend};
      mod1   = {2'b00, modulus};
      mod2   = {1'b0, modulus, 1'b0};
      if (sum >= mod2) begin
         acc_in = WIDTH'(sum - mod2);
      end else if (sum >= mod1) begin
         acc_in = WIDTH'(sum - mod1);
      end else begin
         acc_in = sum[WIDTH-1:0];
      end
   end

   // Control flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && cnt_ff == '0) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else begin
         done_ff <= 1'b0;
      end
   end

   // Operand and accumulator registers.
   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         x_ff      <= mul_x;
         mplier_ff <= mul_y;
         cnt_ff    <= CW'(WIDTH - 1);
      end else if (busy_ff) begin
         acc_ff    <= acc_in;
         mplier_ff <= {mplier_ff[WIDTH-2:0], 1'b0};
         cnt_ff    <= cnt_ff - 1'b1;
      end
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[design/spp_datapath.sv]
module spp_datapath import spp_pkg::*; #(
   parameter int WIDTH = SPP_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spp_cmd_type           cmd,
   output spp_status_type        stat,
   input  logic [SPP_CAND_W-1:0] req_candidate,
   input  logic                  csr_we,
   input  logic [SPP_BASE_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_probable_prime,
   output logic                  rsp_input_error
);

   localparam int CW = $clog2(WIDTH);

   logic [SPP_BASE_W-1:0] base_ff;
   logic [WIDTH-1:0]      n_ff;
   logic [WIDTH-1:0]      m_ff;
   logic [WIDTH-1:0]      r_ff;
   logic [WIDTH-1:0]      y_ff;
   logic [WIDTH-1:0]      w_ff;
   logic [CW-1:0]         s_ff;
   logic [CW-1:0]         j_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_prime_ff;
   logic                  rsp_error_ff;
   logic [WIDTH-1:0]      op_x;
   logic [WIDTH-1:0]      op_y;
   logic                  mul_busy;
   logic                  mul_done;
   logic [WIDTH-1:0]      product;

   // Base register; the user must write it only while idle, the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= SPP_BASE_RESET;
      end else if (csr_we) begin
         base_ff <= csr_wdata;
      end
   end

   // Working registers of the test.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff <= WIDTH'(req_candidate);
         m_ff <= WIDTH'(req_candidate) - WIDTH'(1);
         r_ff <= WIDTH'(req_candidate) - WIDTH'(1);
         y_ff <= WIDTH'(1);
         w_ff <= WIDTH'(base_ff);
         s_ff <= '0;
         j_ff <= CW'(1);
      end else begin
         if (cmd.split_shift) begin
            r_ff <= r_ff >> 1;
            s_ff <= s_ff + 1'b1;
         end else if (cmd.r_shift) begin
            r_ff <= r_ff >> 1;
         end
         if (cmd.y_from_prod) begin
            y_ff <= product;
         end
         if (cmd.w_from_prod) begin
            w_ff <= product;
         end
         if (cmd.j_inc) begin
            j_ff <= j_ff + 1'b1;
         end
      end
   end

   // Multiplier operand selection.
   always_comb begin
      unique case (cmd.mul_op)
         MUL_YW: begin
            op_x = y_ff;
            op_y = w_ff;
         end
         MUL_WW: begin
            op_x = w_ff;
            op_y = w_ff;
         end
         MUL_YY: begin
            op_x = y_ff;
            op_y = y_ff;
         end
         default: begin
            op_x = y_ff;
            op_y = y_ff;
         end
      endcase
   end

   spp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .mul_x  (op_x),
      .mul_y  (op_y),
      .modulus(n_ff),
      .busy   (mul_busy),
      .done   (mul_done),
      .product(product)
   );

   // Output register holds one finished word until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.post) begin
         rsp_prime_ff <= cmd.post_prime;
         rsp_error_ff <= cmd.post_error;
      end
   end

   // Status flags for the controller.
   always_comb begin
      stat.input_bad = (n_ff <= WIDTH'(3)) || !n_ff[0] || (w_ff < WIDTH'(2)) ||
                       (w_ff > n_ff - WIDTH'(2));
      stat.r_lsb     = r_ff[0];
      stat.r_more    = |r_ff[WIDTH-1:1];
      stat.y_is_one  = (y_ff == WIDTH'(1));
      stat.y_is_m    = (y_ff == m_ff);
      stat.y_le_one  = (y_ff <= WIDTH'(1));
      stat.j_lt_s    = (j_ff < s_ff);
      stat.mul_done  = mul_done;
      stat.mul_busy  = mul_busy;
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probable_prime = rsp_prime_ff;
   assign rsp_input_error    = rsp_error_ff;

endmodule

[design/spp_ctrl.sv]
module spp_ctrl import spp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  spp_status_type stat,
   output spp_cmd_type    cmd
);

   spp_state_type state_ff;
   spp_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.input_bad ? ST_POST_ERR : ST_SPLIT;
         end
         ST_SPLIT: begin
            if (stat.r_lsb) state_in = ST_EXP;
         end
         ST_EXP: begin
            state_in = stat.r_lsb ? ST_MUL_Y : ST_SHIFT;
         end
         ST_MUL_Y: begin
            if (stat.mul_done) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            state_in = stat.r_more ? ST_MUL_W : ST_FINAL;
         end
         ST_MUL_W: begin
            if (stat.mul_done) state_in = ST_EXP;
         end
         ST_FINAL: begin
            state_in = stat.y_is_one ? ST_POST_PRIME : ST_SQR_TEST;
         end
         ST_SQR_TEST: begin
            if (stat.j_lt_s && !stat.y_is_m) begin
               state_in = ST_SQR_WAIT;
            end else begin
               state_in = stat.y_is_m ? ST_POST_PRIME : ST_POST_COMP;
            end
         end
         ST_SQR_WAIT: begin
            if (stat.mul_done) state_in = ST_SQR_CHECK;
         end
         ST_SQR_CHECK: begin
            state_in = stat.y_le_one ? ST_POST_COMP : ST_SQR_TEST;
         end
         ST_POST_ERR, ST_POST_PRIME, ST_POST_COMP: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd        = '0;
      cmd.mul_op = MUL_YW;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SPLIT: begin
            cmd.split_shift = !stat.r_lsb;
         end
         ST_EXP: begin
            cmd.mul_start = stat.r_lsb;
            cmd.mul_op    = MUL_YW;
         end
         ST_MUL_Y: begin
            cmd.y_from_prod = stat.mul_done;
         end
         ST_SHIFT: begin
            cmd.r_shift   = 1'b1;
            cmd.mul_start = stat.r_more;
            cmd.mul_op    = MUL_WW;
         end
         ST_MUL_W: begin
            cmd.w_from_prod = stat.mul_done;
         end
         ST_SQR_TEST: begin
            cmd.mul_start = stat.j_lt_s && !stat.y_is_m;
            cmd.mul_op    = MUL_YY;
         end
         ST_SQR_WAIT: begin
            cmd.y_from_prod = stat.mul_done;
            cmd.j_inc       = stat.mul_done;
         end
         ST_POST_ERR: begin
            cmd.post       = stat.out_free;
            cmd.post_error = 1'b1;
         end
         ST_POST_PRIME: begin
            cmd.post       = stat.out_free;
            cmd.post_prime = 1'b1;
         end
         ST_POST_COMP: begin
            cmd.post = stat.out_free;
         end
         ST_CHECK, ST_FINAL, ST_SQR_CHECK: begin
            cmd.post = 1'b0;
         end
         default: begin
            cmd.post = 1'b0;
         end
      endcase
   end

endmodule

[design/strong_probable_prime_test.sv]
// Each word takes s halving steps, where s counts the trailing zeros of n-1,
// and k <= 2*WIDTH modular multiplications on one bit-serial shift-and-add modular multiplier.
// A new word is taken only after the verdict of the last one is stored.
// Reset is synchronous and active high; it idles the controller, empties the output register
// and sets the witness base register to 2.
`include "strong_probable_prime_test_defines.svh"

module strong_probable_prime_test import spp_pkg::*; #(
   parameter int WIDTH = SPP_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SPP_CAND_W-1:0] req_candidate,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_probable_prime,
   output logic                  rsp_input_error,
   input  logic                  csr_we,
   input  logic [SPP_BASE_W-1:0] csr_wdata
);

   spp_cmd_type    cmd;
   spp_status_type stat;

   // Sequencer for the split, exponentiation and squaring phases.
   spp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // Registers, multiplier and output word.
   spp_datapath #(
      .WIDTH(WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_candidate     (req_candidate),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_probable_prime(rsp_probable_prime),
      .rsp_input_error   (rsp_input_error)
   );

   // An input error never comes with a prime verdict.
   `SPP_ASSERT_NOW(a_err_prime, rsp_valid && rsp_input_error, !rsp_probable_prime, "prime on error")
   // After a word is taken the block is busy with it.
   `SPP_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   // The multiplier is never running while the block waits for a word.
   `SPP_ASSERT_NOW(a_idle_mul_quiet, req_ready, !stat.mul_busy, "multiplier busy while idle")

endmodule

[dv/tb_strong_probable_prime_test.sv]
module tb_strong_probable_prime_test;
   import spp_pkg::*;

   // Generous bound: every word at its slowest multiply count, with gaps and stalls.
   localparam int CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic probable_prime;
      logic input_error;
   } verdict_type;

   // Tracks the witness base, predicts each verdict and checks the returned words.
   class verdict_board;
      logic [SPP_BASE_W-1:0] base;
      verdict_type           pending[$];
      int                    mismatches;
      int                    primes_seen;
      int                    composites_seen;
      int                    errors_seen;

      function new();
         base = SPP_BASE_RESET;
         mismatches = 0;
         primes_seen = 0;
         composites_seen = 0;
         errors_seen = 0;
      endfunction

      function void set_base(logic [SPP_BASE_W-1:0] value);
         base = value;
      endfunction

      // One base of Miller-Rabin on an odd n > 3 with 2 <= a <= n-2.
      function bit strong_witness_pass(logic [63:0] n, logic [63:0] a);
         logic [63:0] m;
         logic [63:0] r;
         logic [63:0] y;
         logic [63:0] w;
         int          s;
         int          j;
         m = n - 64'd1;
         r = m;
         s = 0;
         y = 64'd1;
         w = a;
         while (r[0] == 1'b0 && s < 64) begin
            r = r >> 1;
            s++;
         end
         // Square-and-multiply for a^r mod n; operands stay below 2^32.
         while (r != 64'd0) begin
            if (r[0]) begin
               y = (y * w) % n;
            end
            r = r >> 1;
            if (r != 64'd0) begin
               w = (w * w) % n;
            end
         end
         if (y == 64'd1) begin
            return 1'b1;
         end
         for (j = 1; j < s && y != m; j++) begin
            y = (y * y) % n;
            if (y <= 64'd1) begin
               return 1'b0;
            end
         end
         return (y == m);
      endfunction

      // Queues the verdict expected for an accepted candidate word.
      function void note_candidate(logic [SPP_CAND_W-1:0] cand);
         verdict_type v;
         logic [63:0] n;
         logic [63:0] a;
         n = 64'(cand);
         a = 64'(base);
         if (n <= 64'd3 || n[0] == 1'b0 || a < 64'd2 || a > n - 64'd2) begin
            v.probable_prime = 1'b0;
            v.input_error = 1'b1;
         end else begin
            v.probable_prime = strong_witness_pass(n, a);
            v.input_error = 1'b0;
         end
         pending.push_back(v);
      endfunction

      // Compares a returned verdict word with the oldest prediction.
      function void check_verdict(logic prime_bit, logic error_bit);
         verdict_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected verdict word, prime=%0b error=%0b",
                     $time, prime_bit, error_bit);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         if (prime_bit !== want.probable_prime) begin
            $display("%0t: probable_prime mismatch, expected %0b, actual %0b",
                     $time, want.probable_prime, prime_bit);
            mismatches++;
         end
         if (error_bit !== want.input_error) begin
            $display("%0t: input_error mismatch, expected %0b, actual %0b",
                     $time, want.input_error, error_bit);
            mismatches++;
         end
         if (want.input_error) begin
            errors_seen++;
         end else if (want.probable_prime) begin
            primes_seen++;
         end else begin
            composites_seen++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [SPP_CAND_W-1:0] req_candidate;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_probable_prime;
   logic                  rsp_input_error;
   logic                  csr_we;
   logic [SPP_BASE_W-1:0] csr_wdata;

   verdict_board board;
   bit           idle_on;
   int           cycle_count;

   strong_probable_prime_test u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_candidate      (req_candidate),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_probable_prime (rsp_probable_prime),
      .rsp_input_error    (rsp_input_error),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   // Free-running clock with a period of 4.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Cycle counter and watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d verdicts outstanding.",
                  cycle_count, board.pending.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side backpressure, changed at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= !(idle_on && $urandom_range(99) < 23);
   end

   // Observe both handshakes at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_candidate(req_candidate);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_verdict(rsp_probable_prime, rsp_input_error);
         end
      end
   end

   // Presents one candidate word and returns at the falling edge after it is taken.
   task automatic send_candidate(input logic [SPP_CAND_W-1:0] cand);
      while (idle_on && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_candidate <= cand;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   // Holds off the sender until every predicted verdict has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   // Mostly odd candidates above the base with a random bit length, plus noise.
   function automatic logic [SPP_CAND_W-1:0] pick_candidate(input logic [SPP_BASE_W-1:0] base);
      int          kind;
      int          lo;
      int          len;
      logic [63:0] v;
      kind = $urandom_range(99);
      if (kind < 75 && base < 32'h8000_0000) begin
         lo = 3;
         while (lo < 32 && (64'd1 << lo) <= 64'(base) + 64'd2) begin
            lo++;
         end
         do begin
            len = $urandom_range(lo, 32);
            v = (64'($urandom) & ((64'd1 << len) - 64'd1)) | (64'd1 << (len - 1)) | 64'd1;
         end while (v < 64'(base) + 64'd2);
         return v[31:0];
      end else if (kind < 85) begin
         return $urandom;
      end else if (kind < 95) begin
         return $urandom_range(9);
      end
      return $urandom & 32'hFFFF_FFFE;
   endfunction

   // Drains the block, writes a new base, then runs random words against it.
   task automatic run_phase(input logic [SPP_BASE_W-1:0] base, input int count);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= base;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_base(base);
      repeat (count) begin
         send_candidate(pick_candidate(base));
      end
   endtask

   // Stimulus sequence.
   initial begin
      logic [SPP_CAND_W-1:0] edge_words[$];
      board = new();
      idle_on = 1'b1;
      cycle_count = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_candidate = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset base of 2: small, even, prime, composite and pseudoprime candidates.
      edge_words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15,
                     32'd25, 32'd561, 32'd1105, 32'd2047, 32'd3277, 32'd4033,
                     32'd65537, 32'h8000_0001, 32'hFFFF_FFFB, 32'hFFFF_FFFD,
                     32'hFFFF_FFFE, 32'hFFFF_FFFF};
      foreach (edge_words[i]) begin
         send_candidate(edge_words[i]);
      end

      // Base 3 with no idling: random words, then base equal to n-2 and base above n-2.
      idle_on = 1'b0;
      run_phase(32'd3, 40);
      send_candidate(32'd5);
      send_candidate(32'd3);
      idle_on = 1'b1;

      // Bases that are always out of range.
      run_phase(32'd0, 8);
      run_phase(32'd1, 8);
      run_phase(32'hFFFF_FFFF, 8);

      // Base at the top of the range: valid only for the largest candidate.
      run_phase(32'hFFFF_FFFD, 8);
      send_candidate(32'hFFFF_FFFF);
      send_candidate(32'hFFFF_FFFD);

      // Random bases from small to large.
      run_phase($urandom_range(2, 9), 48);
      run_phase($urandom_range(10, 60), 48);
      run_phase($urandom_range(61, 65535), 48);
      run_phase($urandom_range(32'h0001_0000, 32'h7FFF_FFFF), 48);

      drain_results();
      repeat (64) @(posedge clock);

      $display("Checked %0d verdict words: %0d probable primes, %0d composites, %0d input errors.",
               board.primes_seen + board.composites_seen + board.errors_seen,
               board.primes_seen, board.composites_seen, board.errors_seen);
      $display("Bases swept from 0 and 1 through small and large values to 32'hFFFFFFFF.");
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
